// ----- sv/w16pc_pkg.sv -----
// shared types, constants and opcode/operand codes for the word16 processor core
// no dependencies
`default_nettype none
package w16pc_pkg;
    localparam int MEM_WORDS = 65536;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int DIV_STEPS = 32;

    typedef logic [15:0] t_word;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_EXEC  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_REG   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_MRD, S_FETCH, S_OPER, S_OPLIT, S_OPMEM,
        S_EXEC, S_DIV, S_POPW, S_RETW, S_WB
    } t_state;

    localparam logic [4:0] OP_SET = 5'h01;
    localparam logic [4:0] OP_ADD = 5'h02;
    localparam logic [4:0] OP_SUB = 5'h03;
    localparam logic [4:0] OP_MUL = 5'h04;
    localparam logic [4:0] OP_DIV = 5'h05;
    localparam logic [4:0] OP_SHL = 5'h07;
    localparam logic [4:0] OP_SHR = 5'h08;
    localparam logic [4:0] OP_AND = 5'h09;
    localparam logic [4:0] OP_BOR = 5'h0A;
    localparam logic [4:0] OP_XOR = 5'h0B;
    localparam logic [4:0] OP_IFE = 5'h0C;
    localparam logic [4:0] OP_IFN = 5'h0D;
    localparam logic [4:0] OP_IFG = 5'h0E;
    localparam logic [4:0] OP_IFB = 5'h0F;
    localparam logic [4:0] OP_JSR = 5'h10;
    localparam logic [4:0] OP_JMP = 5'h11;
    localparam logic [4:0] OP_PSH = 5'h12;
    localparam logic [4:0] OP_POP = 5'h13;
    localparam logic [4:0] OP_RET = 5'h14;
    localparam logic [4:0] OP_HLT = 5'h15;

    localparam logic [4:0] OPD_POP  = 5'd24;
    localparam logic [4:0] OPD_PEEK = 5'd25;
    localparam logic [4:0] OPD_PUSH = 5'd26;
    localparam logic [4:0] OPD_SP   = 5'd27;
    localparam logic [4:0] OPD_PC   = 5'd28;
    localparam logic [4:0] OPD_OV   = 5'd29;
    localparam logic [4:0] OPD_IND  = 5'd30;
    localparam logic [4:0] OPD_LIT  = 5'd31;

    localparam logic [3:0] RIDX_PC = 4'd8;
    localparam logic [3:0] RIDX_SP = 4'd9;
    localparam logic [3:0] RIDX_OV = 4'd10;
endpackage
`default_nettype wire

// ----- sv/w16pc_ram.sv -----
// generic single-port ram with registered read
// no dependencies
`default_nettype none
module w16pc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ----- sv/w16pc_div.sv -----
// iterative restoring divider, {a,16'h0} / b, one quotient bit per cycle
// depends on w16pc_pkg
`default_nettype none
module w16pc_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire w16pc_pkg::t_word i_dividend,
    input  wire w16pc_pkg::t_word i_divisor,
    output logic                  o_done,
    output logic [31:0]           o_quot
);
    import w16pc_pkg::*;
    localparam int CNT_W = $clog2(DIV_STEPS);

    logic             r_run, n_run;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0]      r_rem, n_rem;
    logic [31:0]      r_q, n_q;
    logic [15:0]      r_dv, n_dv;
    logic [16:0]      w_t;
    logic [16:0]      w_diff;

    assign w_t    = {r_rem, r_q[31]};
    assign w_diff = w_t - {1'b0, r_dv};

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_dv   = r_dv;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_rem = '0;
            n_q   = {i_dividend, 16'h0000};
            n_dv  = i_divisor;
        end else if (r_run) begin
            // shift in next dividend bit, subtract when it fits
            if (!w_diff[16]) begin
                n_rem = w_diff[15:0];
                n_q   = {r_q[30:0], 1'b1};
            end else begin
                n_rem = w_t[15:0];
                n_q   = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
        r_dv  <= n_dv;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// ----- sv/word16_processor_core.sv -----
// word16 processor core: 64k-word memory, dcpu-16 style operands, sequenced datapath
// one memory port, one access a cycle; memory reads pass S_MRD, executes go from S_FETCH on,
//   divides wait in S_DIV; writes, register reads and halted executes end in idle
// throughput: one item at a time, busy high until the result strobe
// reset: a clearing pass writes all 65536 memory words to zero, with busy high
// the result strobe o_valid lasts one cycle; the receiver cannot stall
`default_nettype none
module word16_processor_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       i_command,
    input  wire w16pc_pkg::t_word i_address,
    input  wire w16pc_pkg::t_word i_data_word,
    input  wire logic [3:0]       i_register_index,
    output logic                  o_valid,
    output w16pc_pkg::t_word      o_read_data,
    output w16pc_pkg::t_word      o_program_counter,
    output w16pc_pkg::t_word      o_stack_pointer,
    output logic                  o_zero_mark,
    output logic                  o_carry_mark,
    output logic                  o_halted,
    output logic                  o_unknown_opcode,
    output logic [31:0]           o_cycles_done
);
    import w16pc_pkg::*;

    // architectural state
    t_state      r_state, n_state;
    t_addr       r_clr, n_clr;
    t_word       r_gr [8];
    t_word       n_gr [8];
    t_word       r_ov, n_ov;
    t_word       r_pc, n_pc;
    t_word       r_sp, n_sp;
    logic        r_zf, n_zf;
    logic        r_cf, n_cf;
    logic        r_halt, n_halt;
    logic [31:0] r_icnt, n_icnt;

    // per-item working registers
    logic [14:0] r_ins, n_ins;
    logic        r_sel, n_sel;
    t_word       r_a, n_a;
    t_word       r_b, n_b;
    t_word       r_lit, n_lit;
    t_word       r_res, n_res;
    t_word       r_rd, n_rd;
    logic        r_unk, n_unk;
    logic        r_valid, n_valid;

    // memory port and divider
    logic        ram_we;
    t_addr       ram_addr;
    t_word       ram_wdata;
    t_word       ram_rdata;
    logic        div_start;
    logic        div_done;
    logic [31:0] div_quot;

    // decode
    logic [4:0]  w_op, w_ac, w_code;
    t_word       w_opgr;
    t_word       w_wbgr;
    logic [16:0] w_sum;
    logic [31:0] w_prod;

    assign w_op   = r_ins[4:0];
    assign w_ac   = r_ins[9:5];
    assign w_code = r_sel ? r_ins[14:10] : r_ins[9:5];
    assign w_opgr = r_gr[w_code[2:0]];
    assign w_wbgr = r_gr[w_ac[2:0]];
    assign w_sum  = {1'b0, r_a} + {1'b0, r_b};
    assign w_prod = {16'h0000, r_a} * {16'h0000, r_b};

    w16pc_ram #(
        .WIDTH (16),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    w16pc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    case (i_command)
                        CMD_READ: n_state = S_MRD;
                        CMD_EXEC: n_state = r_halt ? S_IDLE : S_FETCH;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_MRD:   n_state = S_IDLE;
            S_FETCH: n_state = S_OPER;
            S_OPER: begin
                case (w_code) inside
                    [5'd8:5'd15], OPD_POP, OPD_PEEK, OPD_PUSH, OPD_LIT: n_state = S_OPMEM;
                    [5'd16:5'd23], OPD_IND: n_state = S_OPLIT;
                    default: n_state = r_sel ? S_EXEC : S_OPER;
                endcase
            end
            S_OPLIT: n_state = S_OPMEM;
            S_OPMEM: n_state = r_sel ? S_EXEC : S_OPER;
            S_EXEC: begin
                case (w_op) inside
                    OP_SET, OP_ADD, OP_SUB, OP_MUL, [OP_SHL:OP_XOR]: n_state = S_WB;
                    OP_DIV:  n_state = (r_b == '0) ? S_WB : S_DIV;
                    OP_POP:  n_state = S_POPW;
                    OP_RET:  n_state = S_RETW;
                    default: n_state = S_IDLE;
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_WB;
                end
            end
            S_POPW:  n_state = S_WB;
            S_RETW:  n_state = S_IDLE;
            S_WB:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_clr     = r_clr;
        n_gr      = r_gr;
        n_ov      = r_ov;
        n_pc      = r_pc;
        n_sp      = r_sp;
        n_zf      = r_zf;
        n_cf      = r_cf;
        n_halt    = r_halt;
        n_icnt    = r_icnt;
        n_ins     = r_ins;
        n_sel     = r_sel;
        n_a       = r_a;
        n_b       = r_b;
        n_lit     = r_lit;
        n_res     = r_res;
        n_rd      = r_rd;
        n_unk     = r_unk;
        n_valid   = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = r_pc;
        ram_wdata = r_res;
        div_start = 1'b0;
        case (r_state)
            S_CLR: begin
                // zero one word a cycle
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (start) begin
                    n_unk = 1'b0;
                    n_rd  = '0;
                    n_sel = 1'b0;
                    case (i_command)
                        CMD_WRITE: begin
                            ram_we    = 1'b1;
                            ram_addr  = i_address;
                            ram_wdata = i_data_word;
                            n_valid   = 1'b1;
                        end
                        CMD_READ: begin
                            ram_addr = i_address;
                        end
                        CMD_EXEC: begin
                            if (r_halt) begin
                                n_valid = 1'b1;
                            end else begin
                                ram_addr = r_pc;
                                n_pc     = r_pc + 1'b1;
                            end
                        end
                        default: begin
                            case (i_register_index) inside
                                [4'd0:4'd7]: n_rd = r_gr[i_register_index[2:0]];
                                RIDX_PC:     n_rd = r_pc;
                                RIDX_SP:     n_rd = r_sp;
                                RIDX_OV:     n_rd = r_ov;
                                default:     n_rd = '0;
                            endcase
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_MRD: begin
                n_rd    = ram_rdata;
                n_valid = 1'b1;
            end
            S_FETCH: begin
                n_ins = ram_rdata[14:0];
            end
            S_OPER: begin
                case (w_code) inside
                    [5'd8:5'd15]: ram_addr = w_opgr;
                    [5'd16:5'd23], OPD_IND, OPD_LIT: begin
                        ram_addr = r_pc;
                        n_pc     = r_pc + 1'b1;
                    end
                    OPD_POP: begin
                        ram_addr = r_sp;
                        n_sp     = r_sp + 1'b1;
                    end
                    OPD_PEEK: ram_addr = r_sp;
                    OPD_PUSH: begin
                        ram_addr = r_sp - 1'b1;
                        n_sp     = r_sp - 1'b1;
                    end
                    default: begin
                        // register-like operands resolve at once
                        if (r_sel) begin
                            n_b = (w_code == OPD_SP) ? r_sp :
                                  (w_code == OPD_PC) ? r_pc :
                                  (w_code == OPD_OV) ? r_ov : w_opgr;
                        end else begin
                            n_a = (w_code == OPD_SP) ? r_sp :
                                  (w_code == OPD_PC) ? r_pc :
                                  (w_code == OPD_OV) ? r_ov : w_opgr;
                            n_sel = 1'b1;
                        end
                    end
                endcase
            end
            S_OPLIT: begin
                // literal fetched; only operand a keeps it for the write back
                if (!r_sel) begin
                    n_lit = ram_rdata;
                end
                ram_addr = (w_code == OPD_IND) ? ram_rdata : w_opgr + ram_rdata;
            end
            S_OPMEM: begin
                if (r_sel) begin
                    n_b = ram_rdata;
                end else begin
                    n_a   = ram_rdata;
                    n_sel = 1'b1;
                end
            end
            S_EXEC: begin
                if (r_icnt != '1) begin
                    n_icnt = r_icnt + 1'b1;
                end
                n_valid = 1'b1;
                case (w_op)
                    OP_SET: n_res = r_b;
                    OP_ADD: begin
                        n_res = w_sum[15:0];
                        n_cf  = w_sum[16];
                        n_zf  = (w_sum[15:0] == '0);
                    end
                    OP_SUB: begin
                        n_res = r_a - r_b;
                        n_cf  = (r_a < r_b);
                        n_zf  = (r_a == r_b);
                    end
                    OP_MUL: begin
                        n_res = w_prod[15:0];
                        n_ov  = w_prod[31:16];
                    end
                    OP_DIV: begin
                        n_res     = '0;
                        if (r_b == '0) begin
                            n_ov = '0;
                        end
                        div_start = (r_b != '0);
                    end
                    OP_SHL: n_res = (r_b[15:4] != '0) ? '0 : r_a << r_b[3:0];
                    OP_SHR: n_res = (r_b[15:4] != '0) ? '0 : r_a >> r_b[3:0];
                    OP_AND: n_res = r_a & r_b;
                    OP_BOR: n_res = r_a | r_b;
                    OP_XOR: n_res = r_a ^ r_b;
                    OP_IFE: n_pc = (r_a != r_b) ? r_pc + 1'b1 : r_pc;
                    OP_IFN: n_pc = (r_a == r_b) ? r_pc + 1'b1 : r_pc;
                    OP_IFG: n_pc = (r_a <= r_b) ? r_pc + 1'b1 : r_pc;
                    OP_IFB: n_pc = ((r_a & r_b) == '0) ? r_pc + 1'b1 : r_pc;
                    OP_JSR: begin
                        ram_we    = 1'b1;
                        ram_addr  = r_sp;
                        ram_wdata = r_pc;
                        n_sp      = r_sp - 1'b1;
                        n_pc      = r_a;
                    end
                    OP_JMP: n_pc = r_a;
                    OP_PSH: begin
                        ram_we    = 1'b1;
                        ram_addr  = r_sp;
                        ram_wdata = r_a;
                        n_sp      = r_sp - 1'b1;
                    end
                    OP_POP, OP_RET: begin
                        ram_addr = r_sp + 1'b1;
                        n_sp     = r_sp + 1'b1;
                    end
                    OP_HLT: n_halt = 1'b1;
                    default: n_unk = 1'b1;
                endcase
                // strobe only when the item ends here
                case (w_op) inside
                    OP_SET, OP_ADD, OP_SUB, OP_MUL, OP_DIV, [OP_SHL:OP_XOR], OP_POP, OP_RET:
                        n_valid = 1'b0;
                    default: n_valid = 1'b1;
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_res = div_quot[31:16];
                    n_ov  = div_quot[15:0];
                end
            end
            S_POPW: n_res = ram_rdata;
            S_RETW: begin
                n_pc    = ram_rdata;
                n_valid = 1'b1;
            end
            S_WB: begin
                // write back through operand a
                case (w_ac) inside
                    [5'd0:5'd7]: n_gr[w_ac[2:0]] = r_res;
                    [5'd8:5'd15]: begin
                        ram_we   = 1'b1;
                        ram_addr = w_wbgr;
                    end
                    [5'd16:5'd23]: begin
                        ram_we   = 1'b1;
                        ram_addr = w_wbgr + r_lit;
                    end
                    default: ram_we = 1'b0;
                endcase
                n_valid = 1'b1;
            end
            default: n_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            for (int i = 0; i < 8; i++) begin
                r_gr[i] <= '0;
            end
            r_ov    <= '0;
            r_pc    <= '0;
            r_sp    <= 16'hFFFF;
            r_zf    <= 1'b0;
            r_cf    <= 1'b0;
            r_halt  <= 1'b0;
            r_icnt  <= '0;
            r_sel   <= 1'b0;
            r_unk   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_gr    <= n_gr;
            r_ov    <= n_ov;
            r_pc    <= n_pc;
            r_sp    <= n_sp;
            r_zf    <= n_zf;
            r_cf    <= n_cf;
            r_halt  <= n_halt;
            r_icnt  <= n_icnt;
            r_sel   <= n_sel;
            r_unk   <= n_unk;
            r_valid <= n_valid;
        end
        r_ins <= n_ins;
        r_a   <= n_a;
        r_b   <= n_b;
        r_lit <= n_lit;
        r_res <= n_res;
        r_rd  <= n_rd;
    end

    // outputs follow the architectural registers after the item
    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_read_data       = r_rd;
    assign o_program_counter = r_pc;
    assign o_stack_pointer   = r_sp;
    assign o_zero_mark       = r_zf;
    assign o_carry_mark      = r_cf;
    assign o_halted          = r_halt;
    assign o_unknown_opcode  = r_unk;
    assign o_cycles_done     = r_icnt;
endmodule
`default_nettype wire

// ----- tb/sv/word16_processor_core_test.sv -----
// self-checking testbench for word16_processor_core: directed and random command items
// depends on w16pc_pkg and word16_processor_core; predicts each result item and compares
`default_nettype none
module word16_processor_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import w16pc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  i_command = CMD_WRITE;
    t_word       i_address = '0;
    t_word       i_data_word = '0;
    logic [3:0]  i_register_index = '0;
    wire         busy;
    wire         o_valid;
    t_word       o_read_data, o_program_counter, o_stack_pointer;
    logic        o_zero_mark, o_carry_mark, o_halted, o_unknown_opcode;
    logic [31:0] o_cycles_done;

    word16_processor_core dut (.*);

    always #5ns i_clk = ~i_clk;

    // one result item as predicted
    typedef struct packed {
        t_word       rd;
        t_word       pc;
        t_word       sp;
        logic        z;
        logic        c;
        logic        h;
        logic        unk;
        logic [31:0] cnt;
    } t_status;

    // shadow of the core state
    t_word       mem_img [MEM_WORDS];
    t_word       gpr [8];
    t_word       ovf, pc_s, sp_s;
    logic        zf, cf, hf;
    logic [31:0] icount;

    t_status     status_queue[$];
    int          error_count = 0;

    function automatic t_word fetch_word();
        t_word w;
        w = mem_img[pc_s];
        pc_s = pc_s + 16'd1;
        return w;
    endfunction

    function automatic t_word read_operand(logic [4:0] code, inout t_word lit);
        t_word w;
        if (code < 8) return gpr[code[2:0]];
        if (code < 16) return mem_img[gpr[code[2:0]]];
        if (code < 24) begin
            lit = fetch_word();
            return mem_img[t_word'(gpr[code[2:0]] + lit)];
        end
        case (code)
            OPD_POP: begin
                w = mem_img[sp_s];
                sp_s = sp_s + 16'd1;
                return w;
            end
            OPD_PEEK: return mem_img[sp_s];
            OPD_PUSH: begin
                sp_s = sp_s - 16'd1;
                return mem_img[sp_s];
            end
            OPD_SP:  return sp_s;
            OPD_PC:  return pc_s;
            OPD_OV:  return ovf;
            OPD_IND: return mem_img[fetch_word()];
            default: return fetch_word();
        endcase
    endfunction

    function automatic void write_operand(logic [4:0] code, t_word v, t_word lit);
        if (code < 8) gpr[code[2:0]] = v;
        else if (code < 16) mem_img[gpr[code[2:0]]] = v;
        else if (code < 24) mem_img[t_word'(gpr[code[2:0]] + lit)] = v;
    endfunction

    // runs one instruction on the shadow state, returns the unknown-opcode mark
    function automatic logic run_instruction();
        t_word ins, a, b, la, lb;
        logic [4:0] op, ac, bc;
        logic [31:0] r;
        logic unk;
        ins = fetch_word();
        op = ins[4:0];
        ac = ins[9:5];
        bc = ins[14:10];
        la = '0;
        lb = '0;
        unk = 1'b0;
        a = read_operand(ac, la);
        b = read_operand(bc, lb);
        if (icount != 32'hFFFF_FFFF) icount++;
        case (op)
            OP_SET: write_operand(ac, b, la);
            OP_ADD: begin
                r = {16'd0, a} + {16'd0, b};
                cf = r[16];
                write_operand(ac, r[15:0], la);
                zf = (r[15:0] == 0);
            end
            OP_SUB: begin
                r = {16'd0, a - b};
                cf = a < b;
                write_operand(ac, r[15:0], la);
                zf = (r[15:0] == 0);
            end
            OP_MUL: begin
                r = {16'd0, a} * {16'd0, b};
                ovf = r[31:16];
                write_operand(ac, r[15:0], la);
            end
            OP_DIV: begin
                if (b == 0) begin
                    write_operand(ac, '0, la);
                    ovf = '0;
                end else begin
                    r = {a, 16'd0} / {16'd0, b};
                    ovf = r[15:0];
                    write_operand(ac, a / b, la);
                end
            end
            OP_SHL: write_operand(ac, (b >= 16) ? t_word'(0) : t_word'(a << b[3:0]), la);
            OP_SHR: write_operand(ac, (b >= 16) ? t_word'(0) : t_word'(a >> b[3:0]), la);
            OP_AND: write_operand(ac, a & b, la);
            OP_BOR: write_operand(ac, a | b, la);
            OP_XOR: write_operand(ac, a ^ b, la);
            OP_IFE: if (a != b) pc_s = pc_s + 16'd1;
            OP_IFN: if (a == b) pc_s = pc_s + 16'd1;
            OP_IFG: if (a <= b) pc_s = pc_s + 16'd1;
            OP_IFB: if ((a & b) == 0) pc_s = pc_s + 16'd1;
            OP_JSR: begin
                mem_img[sp_s] = pc_s;
                sp_s = sp_s - 16'd1;
                pc_s = a;
            end
            OP_JMP: pc_s = a;
            OP_PSH: begin
                mem_img[sp_s] = a;
                sp_s = sp_s - 16'd1;
            end
            OP_POP: begin
                sp_s = sp_s + 16'd1;
                write_operand(ac, mem_img[sp_s], la);
            end
            OP_RET: begin
                sp_s = sp_s + 16'd1;
                pc_s = mem_img[sp_s];
            end
            OP_HLT: hf = 1'b1;
            default: unk = 1'b1;
        endcase
        return unk;
    endfunction

    function automatic t_status predict_status(logic [1:0] cmd, t_word addr, t_word data,
                                               logic [3:0] ridx);
        t_status s;
        s = '0;
        case (cmd)
            CMD_WRITE: mem_img[addr] = data;
            CMD_EXEC:  if (!hf) s.unk = run_instruction();
            CMD_READ:  s.rd = mem_img[addr];
            default: begin
                if (ridx < 8) s.rd = gpr[ridx[2:0]];
                else if (ridx == RIDX_PC) s.rd = pc_s;
                else if (ridx == RIDX_SP) s.rd = sp_s;
                else if (ridx == RIDX_OV) s.rd = ovf;
            end
        endcase
        s.pc = pc_s;
        s.sp = sp_s;
        s.z = zf;
        s.c = cf;
        s.h = hf;
        s.cnt = icount;
        return s;
    endfunction

    // sends one item after a random gap; start stays high until accepted
    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(logic [1:0] cmd, t_word addr, t_word data, logic [3:0] ridx,
                             bit gaps = 1);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_command <= cmd;
        i_address <= addr;
        i_data_word <= data;
        i_register_index <= ridx;
        // busy only moves at a rising edge, so its value now decides the next edge
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        status_queue = {status_queue, predict_status(cmd, addr, data, ridx)};
        @(negedge i_clk);
    endtask

    // checks every result item against the oldest prediction
    always @(posedge i_clk) begin
        t_status e, g;
        if (i_rst_n && o_valid) begin
            g = {o_read_data, o_program_counter, o_stack_pointer, o_zero_mark, o_carry_mark,
                 o_halted, o_unknown_opcode, o_cycles_done};
            if (status_queue.size() == 0) begin
                $display("%0t: unexpected result item, actual %h", $time, g);
                error_count++;
            end else begin
                e = status_queue.pop_front();
                if (e.rd !== g.rd)
                    $display("%0t: read_data expected %h actual %h", $time, e.rd, g.rd);
                if (e.pc !== g.pc)
                    $display("%0t: program_counter expected %h actual %h", $time, e.pc, g.pc);
                if (e.sp !== g.sp)
                    $display("%0t: stack_pointer expected %h actual %h", $time, e.sp, g.sp);
                if (e.z !== g.z)
                    $display("%0t: zero_mark expected %b actual %b", $time, e.z, g.z);
                if (e.c !== g.c)
                    $display("%0t: carry_mark expected %b actual %b", $time, e.c, g.c);
                if (e.h !== g.h)
                    $display("%0t: halted expected %b actual %b", $time, e.h, g.h);
                if (e.unk !== g.unk)
                    $display("%0t: unknown_opcode expected %b actual %b", $time, e.unk, g.unk);
                if (e.cnt !== g.cnt)
                    $display("%0t: cycles_done expected %h actual %h", $time, e.cnt, g.cnt);
                if (e !== g) error_count++;
            end
        end
    end

    function automatic t_word make_ins(logic [4:0] op, logic [4:0] a, logic [4:0] b);
        return {$urandom_range(0, 1) == 1, b, a, op};
    endfunction

    // stores a list of words at consecutive addresses from base, one write item per word
    task automatic load_words(t_word base, t_word words[$]);
        foreach (words[k]) send_item(CMD_WRITE, base + t_word'(k), words[k], '0);
    endtask

    task automatic test_access_commands();
        send_item(CMD_REG, '0, '0, RIDX_SP);
        send_item(CMD_WRITE, 16'hFFFF, 16'hFFFF, 4'hF);
        send_item(CMD_READ, 16'hFFFF, '0, '0);
        send_item(CMD_WRITE, 16'h0000, 16'hA5A5, '0);
        send_item(CMD_READ, 16'h0000, '0, '0);
        // reads all 16 register indexes; bad register indexes read as zero
        for (int r = 0; r < 16; r++) send_item(CMD_REG, '0, '0, 4'(r));
    endtask

    task automatic test_directed_ops();
        t_word prog[$];
        // set a literal, add to overflow, sub to zero, wide shift, divide by zero,
        // register plus literal destination, unknown opcode, push, pop, call and return
        prog = '{
            {1'b0, OPD_LIT, 5'd0, OP_SET}, 16'hFFFF,
            {1'b0, OPD_LIT, 5'd0, OP_ADD}, 16'h0001,
            {1'b0, 5'd0, 5'd1, OP_SUB},
            {1'b0, OPD_LIT, 5'd1, OP_SET}, 16'd16,
            {1'b0, 5'd1, 5'd0, OP_SHL},
            {1'b0, 5'd2, 5'd3, OP_DIV},
            {1'b0, 5'd1, 5'd16, OP_SET}, 16'hFFF5,
            {1'b1, 5'd0, 5'd0, 5'd6},
            {1'b0, OPD_LIT, OPD_PUSH, OP_SET}, 16'h1234,
            {1'b0, 5'd0, OPD_POP, OP_POP},
            {1'b0, 5'd0, OPD_LIT, OP_JSR}, 16'h0020
        };
        load_words(16'h0000, prog);
        send_item(CMD_WRITE, 16'h0020, {1'b0, 5'd0, 5'd0, OP_RET}, '0);
        repeat (14) send_item(CMD_EXEC, '0, '0, '0);
        for (int r = 0; r < 11; r++) send_item(CMD_REG, '0, '0, 4'(r));
    endtask

    // random programs: mostly valid opcodes, some noise
    task automatic test_random_programs(int n);
        logic [4:0] op;
        int pick;
        t_word w;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                // plant an instruction or operand word near pc
                op = 5'($urandom_range(1, 20));
                if ($urandom_range(0, 9) == 0) op = 5'($urandom);
                if (op == OP_HLT) op = OP_ADD;
                w = ($urandom_range(0, 3) == 0) ? t_word'($urandom) :
                    make_ins(op, 5'($urandom), 5'($urandom));
                // keep the core running until the halt test
                if (w[4:0] == OP_HLT) w[4:0] = OP_ADD;
                send_item(CMD_WRITE, pc_s + t_word'($urandom_range(0, 3)), w, '0);
            end else if (pick < 35) begin
                send_item(CMD_WRITE, ($urandom_range(0, 1) ? sp_s : t_word'($urandom)) +
                          t_word'($urandom_range(0, 2)),
                          $urandom_range(0, 1) ? t_word'($urandom) : t_word'($urandom_range(0, 20)),
                          4'($urandom));
            end else if (pick < 80) begin
                send_item(CMD_EXEC, t_word'($urandom), t_word'($urandom), 4'($urandom));
            end else if (pick < 90) begin
                send_item(CMD_READ, $urandom_range(0, 1) ? t_word'($urandom) : pc_s,
                          t_word'($urandom), 4'($urandom));
            end else begin
                send_item(CMD_REG, t_word'($urandom), t_word'($urandom), 4'($urandom));
            end
        end
    endtask

    task automatic test_halt();
        send_item(CMD_WRITE, pc_s, {1'b1, 5'd3, 5'd7, OP_HLT}, '0);
        send_item(CMD_EXEC, '0, '0, '0);
        repeat (3) send_item(CMD_EXEC, '0, '0, '0);
        send_item(CMD_WRITE, 16'h1111, 16'h2222, '0);
        send_item(CMD_READ, 16'h1111, '0, '0);
        send_item(CMD_REG, '0, '0, RIDX_PC);
    endtask

    initial begin
        foreach (mem_img[k]) mem_img[k] = '0;
        foreach (gpr[k]) gpr[k] = '0;
        ovf = '0;
        pc_s = '0;
        sp_s = 16'hFFFF;
        zf = 0;
        cf = 0;
        hf = 0;
        icount = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // the core clears its memory after reset with busy held high
        test_access_commands();
        test_directed_ops();
        test_random_programs(1350);
        test_halt();
        start <= 1'b0;
        while (status_queue.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (error_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog: clearing pass plus about 1400 items at worst case gap and latency
    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
